[design/bsg_pkg.sv]
`timescale 1ns / 1ps
package bsg_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int FRAC_BITS_DEF  = 8;

  // fixed field widths
  localparam int COORD_W   = 18;
  localparam int WPOS_W    = 10;
  localparam int PIX_W     = 8;
  localparam int DIM_W     = 11;
  localparam int BORDER_W  = 8;
  localparam int WEIGHT_W  = 17;
  localparam int RES_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;
  localparam int S_DATA_W  = 64;
  localparam int M_DATA_W  = 120;
  localparam int M_USED_W  = 116;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER = 2'd2;

  // request kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // window phase of a sample
  localparam logic [1:0] PH_BASE  = 2'd0;
  localparam logic [1:0] PH_RIGHT = 2'd1;
  localparam logic [1:0] PH_BELOW = 2'd2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = 2;
  localparam int FIFO_CW    = 3;

  typedef logic [WEIGHT_W-1:0] weight_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] phase;
    logic       oob;
    logic       inf;
    logic       sx;
    logic       sy;
    weight_t [3:0] w;
  } meta_t;

endpackage

[design/bsg_ram.sv]
`timescale 1ns / 1ps
module bsg_ram import bsg_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/bilinear_sampler_with_gradient.sv]
`timescale 1ns / 1ps
// Bilinear sampler with gradient. The image sits in four RAM banks split by
// column and row parity, so any 2x2 pixel window is one read per bank. A sample
// request is issued on the input side as three windows in turn (base, two right,
// two below). No request of either kind is taken while a sample is issuing or
// while every queue slot is reserved; otherwise writes are taken at one per
// cycle. Each window is read, weighted and summed; the result is pushed after
// the below window into a four-entry output queue. The images banks are not
// cleared: reading a pixel that was never written gives an undefined value.
// Width and height above the maximum are clamped; a sample whose neighbors
// leave the image reports out_of_bounds with zero values and weights.
module bilinear_sampler_with_gradient import bsg_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // write_col, write_row, write_value, coord_x, coord_y
  input  logic [S_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // sample_value, grad_x, grad_y, weight_top_left, weight_top_right,
  // weight_bottom_left, weight_bottom_right, zero pad
  output logic [M_DATA_W-1:0]  m_axis_tdata,
  // in_frame, out_of_bounds
  output logic [1:0]           m_axis_tuser
);

  localparam int IW     = COORD_W - FRAC_BITS;
  localparam int XW     = IW + 2;
  localparam int EW     = 14;
  localparam int FW     = EW + FRAC_BITS + 1;
  localparam int HALF_W = (MAX_WIDTH + 1) / 2;
  localparam int HALF_H = (MAX_HEIGHT + 1) / 2;
  localparam int BDEPTH = HALF_W * HALF_H;
  localparam int AW     = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int PW     = 2 * FRAC_BITS + 2;
  localparam int LSH    = (2 * FRAC_BITS <= 16) ? 16 - 2 * FRAC_BITS : 0;
  localparam int RSH    = (2 * FRAC_BITS > 16) ? 2 * FRAC_BITS - 16 : 0;
  localparam int RBIAS  = (RSH > 0) ? (1 << (RSH - 1)) : 0;
  localparam int TW     = PW + WEIGHT_W;
  localparam int PRW    = WEIGHT_W + PIX_W;
  localparam int SW     = PRW + 2;

  function automatic weight_t to_q16(input logic [PW-1:0] p);
    logic [TW-1:0] t;
    t = TW'(p);
    if (2 * FRAC_BITS <= 16) begin
      t = t << LSH;
    end else begin
      t = (t + TW'(RBIAS)) >> RSH;
    end
    return WEIGHT_W'(t);
  endfunction

  function automatic logic [AW-1:0] bank_addr(input logic [XW-1:0] col,
                                               input logic [XW-1:0] row);
    return AW'(32'(row >> 1) * 32'(HALF_W) + 32'(col >> 1));
  endfunction

  // configuration
  logic [DIM_W-1:0]    width_q, height_q;
  logic [BORDER_W-1:0] border_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(640);
      height_q <= DIM_W'(480);
      border_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_BORDER: border_q <= cfg_data_i[BORDER_W-1:0];
        default: ;
      endcase
    end
  end

  logic [EW-1:0] w_eff, h_eff;
  assign w_eff = (EW'(width_q) > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(width_q);
  assign h_eff = (EW'(height_q) > EW'(MAX_HEIGHT)) ? EW'(MAX_HEIGHT) : EW'(height_q);

  // request fields
  logic [WPOS_W-1:0]  in_wcol, in_wrow;
  logic [PIX_W-1:0]   in_wval;
  logic [COORD_W-1:0] in_cx, in_cy;
  assign in_wcol = s_axis_tdata[9:0];
  assign in_wrow = s_axis_tdata[19:10];
  assign in_wval = s_axis_tdata[27:20];
  assign in_cx   = s_axis_tdata[45:28];
  assign in_cy   = s_axis_tdata[63:46];

  logic [1:0]         phase_q, phase_d;
  logic [FIFO_CW-1:0] resv_q;
  logic               s_fire, sample_fire, write_fire, pop;

  assign s_axis_tready = (phase_q == PH_BASE) && (resv_q < FIFO_CW'(FIFO_DEPTH));
  assign s_fire      = s_axis_tvalid && s_axis_tready;
  assign sample_fire = s_fire && (s_axis_tuser == KIND_SAMPLE);
  assign write_fire  = s_fire && (s_axis_tuser == KIND_WRITE);

  // sample setup: weights, bounds and frame tests
  logic [FRAC_BITS-1:0] fx, fy;
  logic [FRAC_BITS:0]   ofx, ofy;
  logic [IW-1:0]        in_ix, in_iy;
  weight_t [3:0]        wt_d;
  logic                 oob_d, inf_d;
  logic [FW-1:0]        bq;

  assign fx    = in_cx[FRAC_BITS-1:0];
  assign fy    = in_cy[FRAC_BITS-1:0];
  assign ofx   = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, fx};
  assign ofy   = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, fy};
  assign in_ix = in_cx[COORD_W-1:FRAC_BITS];
  assign in_iy = in_cy[COORD_W-1:FRAC_BITS];
  assign bq    = FW'(border_q) << FRAC_BITS;

  always_comb begin
    wt_d[0] = to_q16(PW'(ofx) * PW'(ofy));
    wt_d[1] = to_q16(PW'(fx) * PW'(ofy));
    wt_d[2] = to_q16(PW'(ofx) * PW'(fy));
    wt_d[3] = to_q16(PW'(fx) * PW'(fy));
    oob_d = (EW'(in_ix) + EW'(3) >= w_eff) || (EW'(in_iy) + EW'(3) >= h_eff);
    inf_d = (FW'(in_cx) >= bq) && (FW'(in_cx) + bq < (FW'(w_eff) << FRAC_BITS))
         && (FW'(in_cy) >= bq) && (FW'(in_cy) + bq < (FW'(h_eff) << FRAC_BITS));
  end

  logic [IW-1:0] bx_q, by_q;
  logic          oob_q, inf_q;
  weight_t [3:0] w_q;

  always_ff @(posedge clk_i) begin
    if (sample_fire) begin
      bx_q  <= in_ix;
      by_q  <= in_iy;
      oob_q <= oob_d;
      inf_q <= inf_d;
      w_q   <= wt_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_BASE:  if (sample_fire) phase_d = PH_RIGHT;
      PH_RIGHT: phase_d = PH_BELOW;
      PH_BELOW: phase_d = PH_BASE;
      default:  phase_d = PH_BASE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BASE;
    end else begin
      phase_q <= phase_d;
    end
  end

  // window issue
  logic          is_base;
  logic [XW-1:0] win_x, win_y;
  logic          iss_oob;
  meta_t         meta1_d, meta1_q;

  assign is_base = (phase_q == PH_BASE);
  assign iss_oob = is_base ? oob_d : oob_q;
  assign win_x = XW'(is_base ? in_ix : bx_q) + ((phase_q == PH_RIGHT) ? XW'(2) : XW'(0));
  assign win_y = XW'(is_base ? in_iy : by_q) + ((phase_q == PH_BELOW) ? XW'(2) : XW'(0));

  always_comb begin
    meta1_d.valid = sample_fire || !is_base;
    meta1_d.phase = phase_q;
    meta1_d.oob   = iss_oob;
    meta1_d.inf   = is_base ? inf_d : inf_q;
    meta1_d.sx    = win_x[0];
    meta1_d.sy    = win_y[0];
    meta1_d.w     = is_base ? wt_d : w_q;
  end

  // banks indexed {row parity, column parity}
  logic [AW-1:0]    raddr [4];
  logic [PIX_W-1:0] rdata [4];
  logic [AW-1:0]    waddr;
  logic             wr_ok;
  logic [1:0]       wbank;
  logic [XW-1:0]    bcol [4];
  logic [XW-1:0]    brow [4];

  assign wr_ok = (32'(in_wcol) < 32'(MAX_WIDTH)) && (32'(in_wrow) < 32'(MAX_HEIGHT));
  assign wbank = {in_wrow[0], in_wcol[0]};
  assign waddr = bank_addr(XW'(in_wcol), XW'(in_wrow));

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic CP = b[0];
    localparam logic RP = b[1];
    assign bcol[b]  = win_x + XW'(win_x[0] ^ CP);
    assign brow[b]  = win_y + XW'(win_y[0] ^ RP);
    assign raddr[b] = iss_oob ? '0 : bank_addr(bcol[b], brow[b]);

    bsg_ram #(
      .WIDTH (PIX_W),
      .DEPTH (BDEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (write_fire && wr_ok && (wbank == 2'(b))),
      .waddr_i (waddr),
      .wdata_i (in_wval),
      .raddr_i (raddr[b]),
      .rdata_o (rdata[b])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta1_q <= '0;
    end else begin
      meta1_q <= meta1_d;
    end
  end

  // weighted pixels; role index {bottom, right}
  meta_t          meta2_q;
  logic [PRW-1:0] prod_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta2_q <= '0;
    end else begin
      meta2_q <= meta1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) begin
      prod_q[r] <= PRW'(meta1_q.w[r]) *
                   PRW'(rdata[2'(r) ^ {meta1_q.sy, meta1_q.sx}]);
    end
  end

  // accumulate the three windows
  logic [SW-1:0]        sum;
  logic [SW-1:0]        s00_q, s10_q;
  logic signed [SW:0]   dx, dy;
  logic signed [SW:0]   gx_full, gy_full;
  logic [SW-1:0]        sv_full;
  logic                 push;
  logic [M_USED_W-1:0]  res_data;
  logic [1:0]           res_user;

  assign sum = SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2]) + SW'(prod_q[3]);

  always_ff @(posedge clk_i) begin
    if (meta2_q.valid && meta2_q.phase == PH_BASE) begin
      s00_q <= sum;
    end
    if (meta2_q.valid && meta2_q.phase == PH_RIGHT) begin
      s10_q <= sum;
    end
  end

  assign push    = meta2_q.valid && (meta2_q.phase == PH_BELOW);
  assign dx      = $signed({1'b0, s10_q}) - $signed({1'b0, s00_q});
  assign dy      = $signed({1'b0, sum}) - $signed({1'b0, s00_q});
  assign gx_full = (dx + (SW+1)'(256)) >>> 9;
  assign gy_full = (dy + (SW+1)'(256)) >>> 9;
  assign sv_full = (s00_q + SW'(128)) >> 8;

  always_comb begin
    if (meta2_q.oob) begin
      res_data = '0;
    end else begin
      res_data = {meta2_q.w[3], meta2_q.w[2], meta2_q.w[1], meta2_q.w[0],
                  gy_full[RES_W-1:0], gx_full[RES_W-1:0], sv_full[RES_W-1:0]};
    end
    res_user = {meta2_q.oob, meta2_q.inf};
  end

  // output queue
  logic [M_USED_W-1:0] fq_data [FIFO_DEPTH];
  logic [1:0]          fq_user [FIFO_DEPTH];
  logic [FIFO_PW-1:0]  wptr_q, rptr_q;
  logic [FIFO_CW-1:0]  fcnt_q;

  assign m_axis_tvalid = (fcnt_q != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {(M_DATA_W-M_USED_W)'(0), fq_data[rptr_q]};
  assign m_axis_tuser  = fq_user[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fq_data[wptr_q] <= res_data;
      fq_user[wptr_q] <= res_user;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fcnt_q <= '0;
      resv_q <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop)  rptr_q <= rptr_q + 1'b1;
      fcnt_q <= fcnt_q + FIFO_CW'(push) - FIFO_CW'(pop);
      // queue slots reserved by accepted samples whose results are not yet popped
      resv_q <= resv_q + FIFO_CW'(sample_fire) - FIFO_CW'(pop);
    end
  end

  a_resv_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resv_q <= FIFO_CW'(FIFO_DEPTH))
    else $error("reservation count above queue depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fcnt_q < FIFO_CW'(FIFO_DEPTH)) || pop)
    else $error("result pushed into a full queue");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_fire |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("request taken during a sample's window reads");

  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0)
    else $error("out-of-bounds result carries nonzero values");

endmodule
